[hdl/fcw_pkg.sv]
// Shared types, AES tables and AES round helpers for the cycle-walking Feistel permutation.
// No dependencies; used by the top level.
package fcw_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIDTH,
        S_AES_INIT,
        S_AES,
        S_MIX,
        S_CHECK,
        S_DONE
    } fcw_state_t;

    typedef enum logic [1:0] {
        REG_KEY_HIGH    = 2'd0,
        REG_KEY_LOW     = 2'd1,
        REG_DOMAIN_SIZE = 2'd2
    } fcw_reg_t;

    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;
    localparam logic [3:0] AES_LAST_ROUND = 4'd10;
    localparam logic [31:0] DOMAIN_RESET = 32'd1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] low_mask(input logic [5:0] w);
        return (w >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << w);
    endfunction

    // Next round key; byte 0 sits in the top bits.
    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey.
    function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
                                               input logic last);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] m [16];
        logic [7:0] all;
        logic [127:0] res;
        for (int k = 0; k < 16; k++)
        begin
            s[k] = SBOX[st[127-8*k -: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[c*4+i] = s[((c+i)%4)*4+i];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
            m[c*4]   = t[c*4]   ^ all ^ xtime(t[c*4]   ^ t[c*4+1]);
            m[c*4+1] = t[c*4+1] ^ all ^ xtime(t[c*4+1] ^ t[c*4+2]);
            m[c*4+2] = t[c*4+2] ^ all ^ xtime(t[c*4+2] ^ t[c*4+3]);
            m[c*4+3] = t[c*4+3] ^ all ^ xtime(t[c*4+3] ^ t[c*4]);
        end
        for (int k = 0; k < 16; k++)
        begin
            res[127-8*k -: 8] = (last ? t[k] : m[k]) ^ rk[127-8*k -: 8];
        end
        return res;
    endfunction

endpackage

[hdl/fcw_req_if.sv]
// Request channel: opcode and value_in with valid/ready handshake.
// No dependencies.
interface fcw_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] value_in;

    modport source (output valid, output opcode, output value_in, input ready);
    modport sink (input valid, input opcode, input value_in, output ready);
endinterface

[hdl/fcw_rsp_if.sv]
// Response channel: value_out and range_error with valid/ready handshake.
// No dependencies.
interface fcw_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_out;
    logic        range_error;

    modport source (output valid, output value_out, output range_error, input ready);
    modport sink (input valid, input value_out, input range_error, output ready);
endinterface

[hdl/feistel_cycle_walk_prp.sv]
// Keyed permutation of 0..domain_size-1 (and its inverse) built from a Feistel network
// whose round function is AES-128, with cycle walking back into the domain.
// Depends on fcw_pkg, fcw_req_if and fcw_rsp_if.
//
// One word at a time. A word below domain_size runs P Feistel passes of the walk (1 in the
// common case). The bit length n of domain_size is first found by a shift counter, and a single
// AES round unit with an on-the-fly key schedule runs ten rounds per Feistel round. An
// out-of-domain word skips the rounds and answers with range_error set and a zero value.
// The next word is taken once the sequencer is back in idle, even while a response waits.
module feistel_cycle_walk_prp #(
    parameter int FEISTEL_ROUNDS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    fcw_req_if.sink     req,
    fcw_rsp_if.source   rsp
);

    localparam int FRW = $clog2(FEISTEL_ROUNDS + 1);

    fcw_pkg::fcw_state_t state_reg, state_next;

    logic [63:0]    key_high_reg;
    logic [63:0]    key_low_reg;
    logic [31:0]    domain_reg;
    logic           op_reg, op_next;
    logic [31:0]    blk_reg, blk_next;
    logic [31:0]    t_reg, t_next;
    logic [5:0]     n_reg, n_next;
    logic [FRW-1:0] fr_reg, fr_next;
    logic [3:0]     ar_reg, ar_next;
    logic [127:0]   aes_reg, aes_next;
    logic [127:0]   rk_reg, rk_next;
    logic           err_reg, err_next;
    logic           ovalid_reg, ovalid_next;
    logic [31:0]    oval_reg, oval_next;
    logic           oerr_reg, oerr_next;

    logic [127:0] key;
    logic [5:0]   split;
    logic [5:0]   cat;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [15:0]  fin;
    logic [15:0]  rno;
    logic [31:0]  fmask;
    logic [15:0]  fmix;
    logic [31:0]  part_a;
    logic [31:0]  part_b;
    logic [127:0] rk_step;

    assign key = {key_high_reg, key_low_reg};

    // Split point of the current pass; forward puts the wider half low.
    assign split = (op_reg == fcw_pkg::OP_INVERSE) ? (n_reg >> 1) : (n_reg - (n_reg >> 1));
    assign cat   = n_reg - split;
    assign lo    = blk_reg & fcw_pkg::low_mask(split);
    assign hi    = (blk_reg >> split) & fcw_pkg::low_mask(cat);
    assign fin   = (op_reg == fcw_pkg::OP_INVERSE) ? hi[15:0] : lo[15:0];
    assign rno   = (op_reg == fcw_pkg::OP_INVERSE)
                 ? (16'(FEISTEL_ROUNDS) - 16'(fr_reg)) : (16'(fr_reg) + 16'd1);
    assign fmask = fcw_pkg::low_mask((op_reg == fcw_pkg::OP_INVERSE) ? split : cat);
    assign fmix  = aes_reg[15:0] & fmask[15:0];
    assign part_a = (op_reg == fcw_pkg::OP_INVERSE) ? (lo ^ {16'd0, fmix}) : lo;
    assign part_b = (op_reg == fcw_pkg::OP_INVERSE) ? hi : (hi ^ {16'd0, fmix});
    assign rk_step = fcw_pkg::key_step(rk_reg, fcw_pkg::RCON[ar_reg - 4'd1]);

    assign req.ready   = (state_reg == fcw_pkg::S_IDLE);
    assign rsp.valid       = ovalid_reg;
    assign rsp.value_out   = oval_reg;
    assign rsp.range_error = oerr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            domain_reg   <= fcw_pkg::DOMAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fcw_pkg::REG_KEY_HIGH:    key_high_reg <= cfg_data;
                fcw_pkg::REG_KEY_LOW:     key_low_reg  <= cfg_data;
                fcw_pkg::REG_DOMAIN_SIZE: domain_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fcw_pkg::S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        blk_reg  <= blk_next;
        t_reg    <= t_next;
        n_reg    <= n_next;
        fr_reg   <= fr_next;
        ar_reg   <= ar_next;
        aes_reg  <= aes_next;
        rk_reg   <= rk_next;
        err_reg  <= err_next;
        oval_reg <= oval_next;
        oerr_reg <= oerr_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        blk_next    = blk_reg;
        t_next      = t_reg;
        n_next      = n_reg;
        fr_next     = fr_reg;
        ar_next     = ar_reg;
        aes_next    = aes_reg;
        rk_next     = rk_reg;
        err_next    = err_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        oval_next   = oval_reg;
        oerr_next   = oerr_reg;

        case (state_reg)
            fcw_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.opcode;
                    blk_next = req.value_in;
                    t_next = domain_reg;
                    n_next = '0;
                    fr_next = '0;
                    if (req.value_in >= domain_reg)
                    begin
                        err_next = 1'b1;
                        blk_next = '0;
                        state_next = fcw_pkg::S_DONE;
                    end
                    else
                    begin
                        err_next = 1'b0;
                        state_next = fcw_pkg::S_WIDTH;
                    end
                end
            end
            fcw_pkg::S_WIDTH:
            begin
                if (t_reg == '0)
                begin
                    state_next = fcw_pkg::S_AES_INIT;
                end
                else
                begin
                    t_next = t_reg >> 1;
                    n_next = n_reg + 6'd1;
                end
            end
            fcw_pkg::S_AES_INIT:
            begin
                aes_next = {112'd0, fin ^ rno} ^ key;
                rk_next = key;
                ar_next = 4'd1;
                state_next = fcw_pkg::S_AES;
            end
            fcw_pkg::S_AES:
            begin
                rk_next = rk_step;
                aes_next = fcw_pkg::aes_round(aes_reg, rk_step,
                                              ar_reg == fcw_pkg::AES_LAST_ROUND);
                if (ar_reg == fcw_pkg::AES_LAST_ROUND)
                begin
                    state_next = fcw_pkg::S_MIX;
                end
                else
                begin
                    ar_next = ar_reg + 4'd1;
                end
            end
            fcw_pkg::S_MIX:
            begin
                blk_next = (part_a << cat) | part_b;
                if (fr_reg == FRW'(FEISTEL_ROUNDS - 1))
                begin
                    state_next = fcw_pkg::S_CHECK;
                end
                else
                begin
                    fr_next = fr_reg + FRW'(1);
                    state_next = fcw_pkg::S_AES_INIT;
                end
            end
            fcw_pkg::S_CHECK:
            begin
                fr_next = '0;
                // walk on until the pass lands inside the domain
                state_next = (blk_reg >= domain_reg) ? fcw_pkg::S_AES_INIT : fcw_pkg::S_DONE;
            end
            fcw_pkg::S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    oval_next = blk_reg;
                    oerr_next = err_reg;
                    state_next = fcw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fcw_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.range_error |-> rsp.value_out == '0)
        else $error("range error word carries nonzero value");

    a_in_domain: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.range_error |-> rsp.value_out < domain_reg)
        else $error("result outside domain");

    a_aes_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fcw_pkg::S_AES |-> ar_reg >= 4'd1 && ar_reg <= fcw_pkg::AES_LAST_ROUND)
        else $error("AES round counter out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != fcw_pkg::S_IDLE)
        else $error("sequencer idle right after accept");
`endif

endmodule
